// ===== sv/bmf3_pkg.sv =====
// ----------------------------------------------------------------------------
// bmf3_pkg: shared types and constants for the 3D box mean filter
// Field widths, volume limits, accumulator sizes and register indexes.
// ----------------------------------------------------------------------------
package bmf3_pkg;

   // Field widths
   localparam int COORD_W  = 6;
   localparam int VOXEL_W  = 8;
   localparam int SIZE_W   = 7;
   localparam int RADIUS_W = 5;

   // Volume limits
   localparam int MAX_WIDTH  = 64;
   localparam int MAX_HEIGHT = 64;
   localparam int MAX_DEPTH  = 64;
   localparam int MAX_RADIUS = 31;

   // Store address is {z, y, x}
   localparam int ADDR_W = 3 * COORD_W;

   // Accumulators: count up to 64^3, sum up to 255 * 64^3
   localparam int CNT_W      = 19;
   localparam int SUM_W      = 26;
   localparam int DIVIDEND_W = SUM_W + 1;
   localparam int DIVISOR_W  = CNT_W + 1;
   localparam int QUO_W      = 8;
   localparam int STEP_W     = 3;

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 7;

   localparam logic [CSR_INDEX_W-1:0] CSR_RADIUS       = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_DEPTH  = 2'd3;

   // Item function codes
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   // Result status codes
   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_BOUNDS = 1'b1;

   // Divider request
   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

endpackage

// ===== sv/box_mean_filter_3d.sv =====
// ----------------------------------------------------------------------------
// box_mean_filter_3d: 3D box mean filter over an 8-bit voxel volume
// Holds a 64x64x64 voxel store; returns the rounded mean of a clipped cube.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): func 0 writes voxel_in at (x, y, z); func 1
//   queries the half-up rounded mean of the cube of half side radius around
//   (x, y, z), clipped to the configured image size.
//   Response channel (rsp_*): one transfer per query and per item whose
//   coordinates lie outside the configured size (status 1, value 0). A good
//   write gives no response.
//   A good write leaves the block idle, so the next item can follow in the next cycle.
//   A query scans its clipped window through the single store port, one voxel
//   a cycle, then passes through the drain, prepare and divide states to the
//   result state. An out-of-bounds item goes straight to the result state
//   and from there into the response register.
//   One item is in flight at a time; req_stall is high until it is finished.
//   A finished result waits in the response register while rsp_stall is
//   high, and the next request is taken while it waits.
//   Reset sets radius 1 and all sizes to 64; the store is not cleared and
//   its contents stay undefined until written.
//   Write the csr_* registers only while the block is idle.
// ----------------------------------------------------------------------------
module box_mean_filter_3d (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               csr_write_en,
   input  logic [bmf3_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bmf3_pkg::CSR_DATA_W-1:0]    csr_write_data,

   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_func,
   input  logic [bmf3_pkg::COORD_W-1:0]       req_pos_x,
   input  logic [bmf3_pkg::COORD_W-1:0]       req_pos_y,
   input  logic [bmf3_pkg::COORD_W-1:0]       req_pos_z,
   input  logic [bmf3_pkg::VOXEL_W-1:0]       req_voxel_in,

   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [bmf3_pkg::VOXEL_W-1:0]       rsp_smoothed_value,
   output logic                               rsp_status
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_PREP,
      ST_DIV,
      ST_RESULT
   } state_type;

   localparam int C_W = bmf3_pkg::COORD_W;
   localparam int S_W = bmf3_pkg::SIZE_W;

   state_type                            state_ff;

   // Configuration registers
   logic [bmf3_pkg::RADIUS_W-1:0]        radius_ff;
   logic [S_W-1:0]                       image_width_ff;
   logic [S_W-1:0]                       image_height_ff;
   logic [S_W-1:0]                       image_depth_ff;

   // Window bounds and scan position
   logic [C_W-1:0]                       x0_ff, x1_ff, y0_ff, y1_ff, z1_ff;
   logic [C_W-1:0]                       x_ff, y_ff, z_ff;

   // Accumulators and result
   logic                                 rd_valid_ff;
   logic [bmf3_pkg::VOXEL_W-1:0]         rd_data_ff;
   logic [bmf3_pkg::SUM_W-1:0]           sum_ff;
   logic [bmf3_pkg::CNT_W-1:0]           cnt_ff;
   logic [bmf3_pkg::VOXEL_W-1:0]         res_value_ff;
   logic                                 res_status_ff;
   logic                                 rsp_valid_ff;
   logic [bmf3_pkg::VOXEL_W-1:0]         rsp_value_ff;
   logic                                 rsp_status_ff;

   // Voxel store
   logic [bmf3_pkg::VOXEL_W-1:0]         voxel_store [2**bmf3_pkg::ADDR_W];
   logic [bmf3_pkg::ADDR_W-1:0]          mem_addr;
   logic                                 mem_we;

   // Combinational helpers
   logic [S_W-1:0]                       w_eff, h_eff, d_eff;
   logic                                 req_xfer;
   logic                                 in_bounds;
   logic [C_W-1:0]                       lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
   logic [S_W-1:0]                       sum_x, sum_y, sum_z;
   logic [C_W-1:0]                       r6;
   logic                                 x_last, y_last, z_last;
   logic                                 rsp_free;
   bmf3_pkg::div_req_type                div_req;
   logic                                 div_done;
   logic [bmf3_pkg::QUO_W-1:0]           div_quotient;

   // ------------------------------------------------------------------------
   // Configuration writes
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff       <= bmf3_pkg::RADIUS_W'(1);
         image_width_ff  <= S_W'(bmf3_pkg::MAX_WIDTH);
         image_height_ff <= S_W'(bmf3_pkg::MAX_HEIGHT);
         image_depth_ff  <= S_W'(bmf3_pkg::MAX_DEPTH);
      end else if (csr_write_en) begin
         unique case (csr_index)
            bmf3_pkg::CSR_RADIUS:       radius_ff       <= csr_write_data[bmf3_pkg::RADIUS_W-1:0];
            bmf3_pkg::CSR_IMAGE_WIDTH:  image_width_ff  <= csr_write_data;
            bmf3_pkg::CSR_IMAGE_HEIGHT: image_height_ff <= csr_write_data;
            bmf3_pkg::CSR_IMAGE_DEPTH:  image_depth_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Bounds check and window clipping for the item on the request port
   // ------------------------------------------------------------------------
   // Clamp sizes to the store limits (radius already fits its limit)
   assign w_eff = (image_width_ff  > S_W'(bmf3_pkg::MAX_WIDTH))
                ? S_W'(bmf3_pkg::MAX_WIDTH)  : image_width_ff;
   assign h_eff = (image_height_ff > S_W'(bmf3_pkg::MAX_HEIGHT))
                ? S_W'(bmf3_pkg::MAX_HEIGHT) : image_height_ff;
   assign d_eff = (image_depth_ff  > S_W'(bmf3_pkg::MAX_DEPTH))
                ? S_W'(bmf3_pkg::MAX_DEPTH)  : image_depth_ff;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;

   assign in_bounds = (S_W'(req_pos_x) < w_eff) && (S_W'(req_pos_y) < h_eff)
                   && (S_W'(req_pos_z) < d_eff);

   assign r6    = C_W'(radius_ff);
   assign lo_x  = (req_pos_x >= r6) ? (req_pos_x - r6) : '0;
   assign lo_y  = (req_pos_y >= r6) ? (req_pos_y - r6) : '0;
   assign lo_z  = (req_pos_z >= r6) ? (req_pos_z - r6) : '0;
   assign sum_x = S_W'(req_pos_x) + S_W'(radius_ff);
   assign sum_y = S_W'(req_pos_y) + S_W'(radius_ff);
   assign sum_z = S_W'(req_pos_z) + S_W'(radius_ff);
   assign hi_x  = (sum_x < w_eff) ? sum_x[C_W-1:0] : C_W'(w_eff - 1'b1);
   assign hi_y  = (sum_y < h_eff) ? sum_y[C_W-1:0] : C_W'(h_eff - 1'b1);
   assign hi_z  = (sum_z < d_eff) ? sum_z[C_W-1:0] : C_W'(d_eff - 1'b1);

   // Scan wraps x, then y, then z
   assign x_last = (x_ff == x1_ff);
   assign y_last = (y_ff == y1_ff);
   assign z_last = (z_ff == z1_ff);

   // ------------------------------------------------------------------------
   // Voxel store: one port, written from the request port, read by the scan
   // ------------------------------------------------------------------------
   assign mem_we   = req_xfer && in_bounds && (req_func == bmf3_pkg::FUNC_WRITE);
   assign mem_addr = (state_ff == ST_IDLE) ? {req_pos_z, req_pos_y, req_pos_x}
                                           : {z_ff, y_ff, x_ff};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         voxel_store[mem_addr] <= req_voxel_in;
      end
      rd_data_ff <= voxel_store[mem_addr];
   end

   // ------------------------------------------------------------------------
   // Divider
   // ------------------------------------------------------------------------
   assign div_req.start    = (state_ff == ST_PREP);
   assign div_req.dividend = {sum_ff, 1'b0} + bmf3_pkg::DIVIDEND_W'(cnt_ff);
   assign div_req.divisor  = {cnt_ff, 1'b0};

   bmf3_div u_div (
      .clock        (clock),
      .reset        (reset),
      .div_req      (div_req),
      .div_done     (div_done),
      .div_quotient (div_quotient)
   );

   // ------------------------------------------------------------------------
   // Sequencer: state, read-valid pipe and response valid
   // ------------------------------------------------------------------------
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= (state_ff == ST_SCAN);
         // Raise the response as a result is loaded; drop it once transferred
         if (state_ff == ST_RESULT && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_xfer) begin
                  if (!in_bounds) begin
                     state_ff <= ST_RESULT;
                  end else if (req_func == bmf3_pkg::FUNC_QUERY) begin
                     state_ff <= ST_SCAN;
                  end
               end
            end
            ST_SCAN: begin
               if (x_last && y_last && z_last) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: state_ff <= ST_PREP;
            ST_PREP:  state_ff <= ST_DIV;
            ST_DIV: begin
               if (div_done) begin
                  state_ff <= ST_RESULT;
               end
            end
            ST_RESULT: begin
               if (rsp_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Datapath: window, scan position, accumulation, result hold
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      // Capture the window and start the scan at its low corner
      if (state_ff == ST_IDLE && req_xfer) begin
         x0_ff         <= lo_x;
         x1_ff         <= hi_x;
         y0_ff         <= lo_y;
         y1_ff         <= hi_y;
         z1_ff         <= hi_z;
         x_ff          <= lo_x;
         y_ff          <= lo_y;
         z_ff          <= lo_z;
         sum_ff        <= '0;
         cnt_ff        <= '0;
         res_value_ff  <= '0;
         res_status_ff <= in_bounds ? bmf3_pkg::STATUS_OK : bmf3_pkg::STATUS_BOUNDS;
      end

      // Advance the scan position
      if (state_ff == ST_SCAN) begin
         if (!x_last) begin
            x_ff <= x_ff + 1'b1;
         end else begin
            x_ff <= x0_ff;
            if (!y_last) begin
               y_ff <= y_ff + 1'b1;
            end else begin
               y_ff <= y0_ff;
               z_ff <= z_ff + 1'b1;
            end
         end
      end

      // Accumulate each voxel as its read data returns
      if (rd_valid_ff) begin
         sum_ff <= sum_ff + bmf3_pkg::SUM_W'(rd_data_ff);
         cnt_ff <= cnt_ff + 1'b1;
      end

      // Hold the mean until the response register is free
      if (state_ff == ST_DIV && div_done) begin
         res_value_ff <= div_quotient;
      end

      // Load the response register
      if (state_ff == ST_RESULT && rsp_free) begin
         rsp_value_ff  <= res_value_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_smoothed_value = rsp_value_ff;
   assign rsp_status         = rsp_status_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   // A new response only comes from the result state
   a_rsp_from_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESULT))
      else $error("response raised outside the result state");

   // The divider finishes only while the sequencer waits for it
   a_div_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide state");

   // Read data returns only for reads issued by the scan
   a_rd_from_scan: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> (state_ff == ST_SCAN || state_ff == ST_DRAIN))
      else $error("read data returned outside the scan");

   // A flagged item carries a zero value
   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == bmf3_pkg::STATUS_BOUNDS) |-> (rsp_value_ff == '0))
      else $error("flagged response with a non-zero value");

endmodule

// ===== sv/bmf3_div.sv =====
// ----------------------------------------------------------------------------
// bmf3_div: restoring divider for the rounded mean
// Produces one quotient bit per cycle, eight bits per division. The
// quotient is known to stay below 256, so only the low eight bits are formed.
// ----------------------------------------------------------------------------
module bmf3_div (
   input  logic                         clock,
   input  logic                         reset,
   input  bmf3_pkg::div_req_type        div_req,
   output logic                         div_done,
   output logic [bmf3_pkg::QUO_W-1:0]   div_quotient
);

   logic                              busy_ff;
   logic                              done_ff;
   logic [bmf3_pkg::STEP_W-1:0]       step_ff;
   logic [bmf3_pkg::DIVIDEND_W-1:0]   rem_ff;
   logic [bmf3_pkg::DIVISOR_W-1:0]    den_ff;
   logic [bmf3_pkg::QUO_W-1:0]        quo_ff;
   logic [bmf3_pkg::DIVIDEND_W-1:0]   trial;
   logic                              fits;

   // Shifted divisor for the current quotient bit
   assign trial = bmf3_pkg::DIVIDEND_W'(den_ff) << step_ff;
   assign fits  = (rem_ff >= trial);

   // Control: run for one pass of the step counter, pulse done at the end
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (step_ff == '0)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // Datapath: load operands, then subtract where the shifted divisor fits
   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff  <= div_req.dividend;
         den_ff  <= div_req.divisor;
         step_ff <= '1;
         quo_ff  <= '0;
      end else if (busy_ff) begin
         if (fits) begin
            rem_ff          <= rem_ff - trial;
            quo_ff[step_ff] <= 1'b1;
         end
         step_ff <= step_ff - 1'b1;
      end
   end

   assign div_done     = done_ff;
   assign div_quotient = quo_ff;

endmodule
